[rtl/tdfsm_pkg.sv]
// Shared types and constants for the table-driven state machine engine.
// No dependencies; imported by tdfsm_table and table_driven_fsm_engine_unit.
package tdfsm_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_SIGNAL = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } seq_state_e;

  // Configuration register select (paddr bit 2)
  localparam logic REG_STATE_COUNT  = 1'b0;
  localparam logic REG_SIGNAL_COUNT = 1'b1;

  localparam int unsigned CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  // One transition slot as stored in the table
  typedef struct packed {
    logic [3:0] target;
    logic [3:0] signal;
    logic       valid;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Input beat, first field in the lowest bits
  typedef struct packed {
    logic [4:0] pad;
    logic [3:0] signal_id;
    logic [3:0] initial_state;
    logic [3:0] slot_target;
    logic [3:0] slot_signal;
    logic       slot_valid;
    logic [3:0] slot_index;
    logic [3:0] slot_state;
    cmd_e       cmd;
  } in_beat_t;

  // Result beat, first field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        fault;
    logic [15:0] run_iteration;
    logic [3:0]  prior_signal;
    logic        prior_signal_valid;
    logic [3:0]  active_state;
    logic        entry_event;
    logic [3:0]  left_state;
    logic        exit_event;
    logic        accepted;
  } out_beat_t;

endpackage

[rtl/tdfsm_table.sv]
// Transition table: one row of slots per state in a synchronous memory,
// with per-row valid bits standing in for the cleared reset contents. Uses tdfsm_pkg.
module tdfsm_table
  import tdfsm_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned MAX_SIGNALS = 16,
  localparam int unsigned RowW    = $clog2(MAX_STATES),
  localparam int unsigned RowBits = MAX_SIGNALS * SLOT_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [RowW-1:0]    rd_addr_i,
  output logic [RowBits-1:0] rd_row_o,
  input  logic               wr_en_i,
  input  logic [RowW-1:0]    wr_addr_i,
  input  logic [RowBits-1:0] wr_row_i
);

  logic [RowBits-1:0]    mem [MAX_STATES];
  logic [RowBits-1:0]    rd_q;
  logic [MAX_STATES-1:0] row_valid_q;
  logic                  row_ok_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Track rows written since reset; an unwritten row reads as terminators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      row_ok_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        row_ok_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = row_ok_q ? rd_q : '0;

endmodule

[rtl/table_driven_fsm_engine_unit.sv]
// Top level of the table-driven state machine engine: stream ports, APB
// register port, sequencer and state registers. Uses tdfsm_pkg and tdfsm_table.
//
// Usage:
//   s_axis carries command beats (load slot, set initial state, signal, run
//   tick); m_axis returns exactly one result beat per command beat, in order.
//   The APB port holds state_count (0x0) and signal_count (0x4); write them
//   only while no command is in flight.
// Timing:
//   Each command has a fetch step, which reads the state's row of slots from
//   the table memory (load and signal only), and an execute step, which
//   searches the row, updates the state and writes a loaded row back. The
//   result is registered and appears on m_axis the cycle after the execute
//   step. One command is in flight; the next is taken once it has executed.
// Stall:
//   A result waiting on m_axis does not block taking the next command; that
//   command holds in its second step until the output register frees up.
// Reset:
//   Asynchronous, active low. The table reads as all terminators right after
//   reset (per-row valid bits), so no clearing pass is needed; both count
//   registers return to 1, the fault flag and all state marks clear.
module table_driven_fsm_engine_unit
  import tdfsm_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned MAX_SIGNALS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cmd, slot_state, slot_index, slot_valid, slot_signal, slot_target,
  // initial_state, signal_id, zero pad
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // accepted, exit_event, left_state, entry_event, active_state,
  // prior_signal_valid, prior_signal, run_iteration, fault, zero pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned RowW    = $clog2(MAX_STATES);

  typedef slot_t [MAX_SIGNALS-1:0] row_t;

  seq_state_e state_q, state_d;
  in_beat_t   s_item, item_q;
  out_beat_t  out_d, out_q;
  logic       m_valid_q;

  logic [CFG_W-1:0] st_cnt_q, sig_cnt_q;

  logic        cur_valid_q, cur_valid_d;
  logic [3:0]  cur_state_q, cur_state_d;
  logic        pend_valid_q, pend_valid_d;
  logic [3:0]  pend_state_q, pend_state_d;
  logic        last_valid_q, last_valid_d;
  logic [3:0]  last_sig_q, last_sig_d;
  logic [15:0] iter_q, iter_d;
  logic        fault_q, fault_d;

  logic            in_fire, exec_fire, cfg_wr;
  logic            rd_en, wr_en;
  logic [RowW-1:0] rd_addr;
  row_t            rd_row, wr_row;
  logic            srch_done, srch_hit;
  logic [3:0]      srch_tgt;
  logic            cur_ok, pend_ok, differ;

  assign s_item          = in_beat_t'(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign exec_fire       = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready_i);

  // Register port: always ready, write on the access beat
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_cnt_q  <= CFG_RESET;
      sig_cnt_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STATE_COUNT:  st_cnt_q  <= pwdata[CFG_W-1:0];
        REG_SIGNAL_COUNT: sig_cnt_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STATE_COUNT:  prdata = 32'(st_cnt_q);
      REG_SIGNAL_COUNT: prdata = 32'(sig_cnt_q);
      default:          prdata = '0;
    endcase
  end

  // Pick the row to fetch: the loaded state's row, or the current state's row
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = RowW'(cur_state_q);
    if (in_fire) begin
      case (s_item.cmd)
        CMD_LOAD: begin
          rd_addr = RowW'(s_item.slot_state);
          rd_en   = (int'(s_item.slot_state) < MAX_STATES);
        end
        CMD_SIGNAL: begin
          rd_en = cur_valid_q && (int'(cur_state_q) < MAX_STATES);
        end
        default: ;
      endcase
    end
  end

  tdfsm_table #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SIGNALS (MAX_SIGNALS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (RowW'(item_q.slot_state)),
    .wr_row_i  (wr_row)
  );

  // Scan the fetched row in slot order; stop at the first terminator
  always_comb begin
    srch_done = 1'b0;
    srch_hit  = 1'b0;
    srch_tgt  = '0;
    for (int j = 0; j < MAX_SIGNALS; j++) begin
      if (!srch_done && (j < int'(sig_cnt_q))) begin
        if (!rd_row[j].valid) begin
          srch_done = 1'b1;
        end else if (rd_row[j].signal == item_q.signal_id) begin
          srch_hit  = 1'b1;
          srch_tgt  = rd_row[j].target;
          srch_done = 1'b1;
        end
      end
    end
  end

  // Merge a loaded slot into the fetched row
  always_comb begin
    wr_row = rd_row;
    for (int j = 0; j < MAX_SIGNALS; j++) begin
      if (j == int'(item_q.slot_index)) begin
        wr_row[j].valid  = item_q.slot_valid;
        wr_row[j].signal = item_q.slot_signal;
        wr_row[j].target = item_q.slot_target;
      end
    end
  end

  assign cur_ok  = cur_valid_q && (cur_state_q < 4'(st_cnt_q) || st_cnt_q[4])
                   && (int'(cur_state_q) < MAX_STATES);
  assign pend_ok = pend_valid_q && (pend_state_q < 4'(st_cnt_q) || st_cnt_q[4])
                   && (int'(pend_state_q) < MAX_STATES);
  assign differ  = !pend_valid_q || !cur_valid_q || (pend_state_q != cur_state_q);

  // Execute the held command against the fetched row
  always_comb begin
    cur_valid_d  = cur_valid_q;
    cur_state_d  = cur_state_q;
    pend_valid_d = pend_valid_q;
    pend_state_d = pend_state_q;
    last_valid_d = last_valid_q;
    last_sig_d   = last_sig_q;
    iter_d       = iter_q;
    fault_d      = fault_q;
    wr_en        = 1'b0;
    out_d        = '0;
    case (item_q.cmd)
      CMD_LOAD: begin
        wr_en = exec_fire && (int'(item_q.slot_state) < MAX_STATES)
                && (int'(item_q.slot_index) < MAX_SIGNALS);
      end
      CMD_INIT: begin
        if ((item_q.initial_state < 4'(st_cnt_q) || st_cnt_q[4])
            && (int'(item_q.initial_state) < MAX_STATES)) begin
          pend_valid_d   = 1'b1;
          pend_state_d   = item_q.initial_state;
          cur_valid_d    = 1'b0;
          cur_state_d    = '0;
          last_valid_d   = 1'b0;
          last_sig_d     = '0;
          out_d.accepted = 1'b1;
        end
      end
      CMD_SIGNAL: begin
        if (cur_ok && srch_hit) begin
          pend_valid_d   = 1'b1;
          pend_state_d   = srch_tgt;
          last_valid_d   = 1'b1;
          last_sig_d     = item_q.signal_id;
          out_d.accepted = 1'b1;
        end
      end
      CMD_RUN: begin
        if (differ && !pend_ok) begin
          fault_d = 1'b1;
        end else if (differ) begin
          out_d.exit_event  = cur_ok;
          out_d.left_state  = cur_ok ? cur_state_q : 4'd0;
          cur_valid_d       = 1'b1;
          cur_state_d       = pend_state_q;
          out_d.entry_event = 1'b1;
          out_d.run_iteration = '0;
          iter_d            = 16'd1;
        end else begin
          out_d.run_iteration = iter_q;
          iter_d              = iter_q + 16'd1;
        end
      end
      default: ;
    endcase
    out_d.active_state       = cur_valid_d ? cur_state_d : 4'd0;
    out_d.prior_signal_valid = last_valid_d;
    out_d.prior_signal       = last_valid_d ? last_sig_d : 4'd0;
    out_d.fault              = fault_d;
  end

  // Sequencer: fetch, then execute once the output register can take the beat
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (exec_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_valid_q    <= 1'b0;
      cur_valid_q  <= 1'b0;
      cur_state_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_state_q <= '0;
      last_valid_q <= 1'b0;
      last_sig_q   <= '0;
      iter_q       <= '0;
      fault_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        m_valid_q    <= 1'b1;
        cur_valid_q  <= cur_valid_d;
        cur_state_q  <= cur_state_d;
        pend_valid_q <= pend_valid_d;
        pend_state_q <= pend_state_d;
        last_valid_q <= last_valid_d;
        last_sig_q   <= last_sig_d;
        iter_q       <= iter_d;
        fault_q      <= fault_d;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold the command beat and the result beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= s_item;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  // A new result beat only comes out of the execute step
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result beat raised without an execute step");

  // An accepted command beat always moves to the execute step
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_EXEC)
    else $error("accepted command did not enter execute");

  // The fault flag never clears outside reset
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("fault flag cleared");

  // With no current state the state register reads zero
  a_idle_state_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> cur_state_q == 4'd0)
    else $error("current state nonzero while invalid");

endmodule
